[hdl/rgbob_pkg.sv]
// Package for the A1R5G5B5 opacity compositor.
// Holds the payload and configuration types, register indexes and the channel mix.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbob_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_OPACITY      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COPY_MODE    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_KEYED = 2'd2;

	localparam logic [7:0] OPACITY_NONE   = 8'd0;
	localparam logic [7:0] OPACITY_OPAQUE = 8'd255;

	localparam int ALPHA_BIT = 15;

	typedef struct packed {
		logic [15:0] src_px;
		logic [15:0] dst_px;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_pixel;
		logic        write_enable;
	} out_item_t;

	typedef struct packed {
		logic [7:0] opacity;
		logic       copy_mode;
		logic       source_keyed;
	} cfg_t;

	// (s*w + (32-w)*d) >> 5 on one 5-bit channel; the sum stays below 1024
	function automatic logic [4:0] mix_channel(input logic [4:0] s, input logic [4:0] d,
		input logic [4:0] w);
		logic [9:0] sum;
		sum = ({5'd0, s} * {5'd0, w}) + ((10'd32 - {5'd0, w}) * {5'd0, d});
		return sum[9:5];
	endfunction

endpackage

`default_nettype wire

[hdl/rgb555_opacity_blend.sv]
// A1R5G5B5 constant-opacity compositor, top level.
// Path from input accept to result accept: input register, then result register.
// Throughput: one item per cycle while the output is not stalled; the per-pixel path is one short compose stage.
// in_stall rises only when both registers hold items and the output is stalled.
// Reset clears both valid flags; opacity resets to 255, copy_mode 0, source_keyed 1.
`timescale 1ns / 1ps
`default_nettype none

module rgb555_opacity_blend
	import rgbob_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel pairs in
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_item_t               in_item,
	// results out
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_item
);

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t result;
	logic      adv_s2;
	logic      load_s1;

	rgbob_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register moves whenever it is empty or its item is being taken.
	assign adv_s2   = !valid_s2 || !out_stall;
	// Hold the input only when the input register is full and cannot drain.
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	// Input register: capture the pixel pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s2) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_item;
		end
	end

	// Compose between the two registers; config must be kept stable while items are in flight (not enforced here).
	rgbob_compose u_compose (
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	// Result register: advance when the output side allows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

endmodule

`default_nettype wire

[hdl/rgbob_cfg.sv]
// Configuration registers of the opacity compositor.
// Depends on rgbob_pkg for the register indexes and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module rgbob_cfg
	import rgbob_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.opacity      <= OPACITY_OPAQUE;
			cfg_q.copy_mode    <= 1'b0;
			cfg_q.source_keyed <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_OPACITY:      cfg_q.opacity      <= cfg_data;
				REG_COPY_MODE:    cfg_q.copy_mode    <= cfg_data[0];
				REG_SOURCE_KEYED: cfg_q.source_keyed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hdl/rgbob_compose.sv]
// Combinational compositing of one pixel pair under the current configuration.
// Depends on rgbob_pkg for the item types and mix_channel.
`timescale 1ns / 1ps
`default_nettype none

module rgbob_compose
	import rgbob_pkg::*;
(
	input  wire cfg_t     cfg,
	input  wire in_item_t item,
	output out_item_t     result
);

	logic       src_alpha;
	logic [4:0] weight;
	logic [15:0] blended;

	assign src_alpha = item.src_px[ALPHA_BIT];
	assign weight    = cfg.opacity[7:3];

	assign blended = {1'b1,
		mix_channel(item.src_px[14:10], item.dst_px[14:10], weight),
		mix_channel(item.src_px[9:5],   item.dst_px[9:5],   weight),
		mix_channel(item.src_px[4:0],   item.dst_px[4:0],   weight)};

	always_comb begin
		result.out_pixel    = item.dst_px;
		result.write_enable = 1'b0;
		priority if (cfg.opacity == OPACITY_NONE) begin
			result.write_enable = 1'b0;
		end else if (cfg.copy_mode) begin
			result.write_enable = 1'b1;
			result.out_pixel    = item.src_px;
		end else if (cfg.opacity == OPACITY_OPAQUE) begin
			if (src_alpha) begin
				result.write_enable = 1'b1;
				result.out_pixel    = item.src_px;
			end
		end else begin
			if (!cfg.source_keyed || src_alpha) begin
				result.write_enable = 1'b1;
				result.out_pixel    = blended;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/rgbob_check.sv]
// Port-level checker for the opacity compositor, bound to the top level.
// Depends on rgbob_pkg and on the top level rgb555_opacity_blend.
`timescale 1ns / 1ps
`default_nettype none

module rgbob_check
	import rgbob_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   cfg_write,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire out_item_t              out_item
);

	logic [7:0] opacity_q;

	// Shadow of the opacity register as seen on the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= OPACITY_OPAQUE;
		end else if (cfg_write && cfg_index == REG_OPACITY) begin
			opacity_q <= cfg_data;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// The input is held back only while the output side is backed up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// An item accepted while no result is held is followed by a valid output once it has passed both registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1 out_valid)
		else $error("accepted item did not reach the output");

	// Zero opacity never writes.
	a_zero_opacity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && opacity_q == OPACITY_NONE |-> !out_item.write_enable)
		else $error("write at zero opacity");

endmodule

bind rgb555_opacity_blend rgbob_check u_rgbob_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_write (cfg_write),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire
